>>> rtl/bdpc_pkg.sv
// shared types and constants for the button debounce and press classifier
package bdpc_pkg;

    localparam int TIME_W     = 32;
    localparam int MS_CFG_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS_MS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS  = 8'd3;

    // configuration reset values
    localparam logic                RST_ACTIVE_LEVEL   = 1'b0;
    localparam logic [MS_CFG_W-1:0] RST_DEBOUNCE_MS    = 16'd50;
    localparam logic [MS_CFG_W-1:0] RST_SHORT_PRESS_MS = 16'd100;
    localparam logic [MS_CFG_W-1:0] RST_LONG_PRESS_MS  = 16'd1000;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_SHORT = 2'd1,
        CLASS_LONG  = 2'd2
    } press_class_t;

    typedef struct packed {
        logic                active_level;
        logic [MS_CFG_W-1:0] debounce_ms;
        logic [MS_CFG_W-1:0] short_press_ms;
        logic [MS_CFG_W-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic         debounced_pressed;
        logic         press_event;
        logic         release_event;
        press_class_t press_class;
    } result_t;

    // true when a 32-bit time difference is strictly above a 16-bit limit
    function automatic logic exceeds(input logic [TIME_W-1:0] diff,
                                     input logic [MS_CFG_W-1:0] limit);
        return (|diff[TIME_W-1:MS_CFG_W]) || (diff[MS_CFG_W-1:0] > limit);
    endfunction

endpackage

>>> rtl/bdpc_tracker.sv
// debounce state, press timing and classification for one sample a cycle while step_en is high
module bdpc_tracker
    import bdpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              step_en,
    input  logic              raw_level,
    input  logic [TIME_W-1:0] now_ms,
    output result_t           result
);

    logic              prev_sample_reg, prev_sample_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic              stable_state_reg, stable_state_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;

    logic              act;
    logic              changed;
    logic              flip;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] press_len;

    always_comb begin
        act       = (raw_level == cfg.active_level);
        changed   = (act != prev_sample_reg);
        elapsed   = now_ms - change_time_reg;
        press_len = now_ms - press_start_reg;
        // a sample that changed the level restarts the timer at zero, so it never flips
        flip      = !changed && exceeds(elapsed, cfg.debounce_ms) && (act != stable_state_reg);

        prev_sample_next  = act;
        change_time_next  = changed ? now_ms : change_time_reg;
        stable_state_next = flip ? act : stable_state_reg;
        press_start_next  = (flip && act) ? now_ms : press_start_reg;

        result.debounced_pressed = stable_state_next;
        result.press_event       = flip && act;
        result.release_event     = flip && !act;
        result.press_class       = CLASS_NONE;
        if (flip && !act) begin
            priority if (exceeds(press_len, cfg.long_press_ms)) begin
                result.press_class = CLASS_LONG;
            end else if (exceeds(press_len, cfg.short_press_ms)) begin
                result.press_class = CLASS_SHORT;
            end else begin
                result.press_class = CLASS_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg  <= 1'b0;
            change_time_reg  <= '0;
            stable_state_reg <= 1'b0;
            press_start_reg  <= '0;
        end else if (step_en) begin
            prev_sample_reg  <= prev_sample_next;
            change_time_reg  <= change_time_next;
            stable_state_reg <= stable_state_next;
            press_start_reg  <= press_start_next;
        end
    end

endmodule

>>> rtl/button_debounce_press_classifier_core.sv
// Button debouncer with short/long press classification. Each input transfer carries one pin
// sample and its millisecond timestamp and yields exactly one result transfer with the debounced
// state, press/release event flags and, on release, the press class. A sample passes an input
// register and then an output register whose valid flag drives m_tvalid, and one sample is
// taken every cycle unless the result side applies backpressure, which is the only limit on
// rate. Configuration is written through the cfg channel (always ready); the user must write
// it only while no sample is in flight, which the block itself does not enforce.
module button_debounce_press_classifier_core
    import bdpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] raw_level, [32:1] now_ms, rest zero
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [0] debounced_pressed, [1] press_event,
                                             // [2] release_event, [4:3] press_class, rest zero
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              in_raw_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    result_t           step_result;
    logic              advance;
    logic              s_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level   <= RST_ACTIVE_LEVEL;
            cfg_reg.debounce_ms    <= RST_DEBOUNCE_MS;
            cfg_reg.short_press_ms <= RST_SHORT_PRESS_MS;
            cfg_reg.long_press_ms  <= RST_LONG_PRESS_MS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACTIVE_LEVEL:   cfg_reg.active_level   <= cfg_data[0];
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= cfg_data;
                REG_SHORT_PRESS_MS: cfg_reg.short_press_ms <= cfg_data;
                REG_LONG_PRESS_MS:  cfg_reg.long_press_ms  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the held sample moves on when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_raw_reg <= s_tdata[0];
            in_now_reg <= s_tdata[TIME_W:1];
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    bdpc_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .step_en   (advance),
        .raw_level (in_raw_reg),
        .now_ms    (in_now_reg),
        .result    (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.press_class, out_data_reg.release_event,
                       out_data_reg.press_event, out_data_reg.debounced_pressed};

endmodule

>>> rtl/bdpc_checker.sv
// port-level checks for the button debounce and press classifier
module bdpc_checker
    import bdpc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a class is only reported together with a release
    a_class_only_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] != CLASS_NONE) |-> m_tdata[2])
        else $error("press class without release event");

    a_events_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("press and release in one transfer");

    // event flags agree with the debounced state they lead to
    a_event_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]) && (!m_tdata[2] || !m_tdata[0]))
        else $error("event flag disagrees with debounced state");

    a_class_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:3] == CLASS_NONE) || (m_tdata[4:3] == CLASS_SHORT)
                     || (m_tdata[4:3] == CLASS_LONG))
        else $error("undefined press class code");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/testbench.sv
// self-checking testbench for the button debounce and press classifier core
module testbench;
    import bdpc_pkg::*;

    typedef struct packed {
        logic              raw;
        logic [TIME_W-1:0] now_ms;
        logic              typed;
        result_t           want;
    } sample_row_t;

    localparam result_t RELEASED_QUIET = '{1'b0, 1'b0, 1'b0, CLASS_NONE};
    localparam result_t PRESSED_QUIET  = '{1'b1, 1'b0, 1'b0, CLASS_NONE};
    localparam result_t PRESS_EDGE     = '{1'b1, 1'b1, 1'b0, CLASS_NONE};
    localparam int      HOLDOFF_CYCLES = 80;
    localparam int      PHASE_SAMPLES  = 225;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // [0] raw_level, [32:1] now_ms, rest zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [0] debounced_pressed, [1] press_event,
                                            // [2] release_event, [4:3] press_class

    button_debounce_press_classifier_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // button model state
    cfg_t              cfg_model;
    logic              pin_was_active;
    logic [TIME_W-1:0] pin_edge_ms;
    logic              btn_pressed;
    logic [TIME_W-1:0] press_start_ms;

    result_t           button_results_due[$];
    int unsigned       mismatches      = 0;
    int unsigned       samples_sent    = 0;
    int unsigned       burst_left      = 0;
    int unsigned       holdoff_requests = 0;
    logic [TIME_W-1:0] sample_ms       = '0;

    sample_row_t directed_rows [25] = '{
        '{1'b1, 32'd0,          1'b1, RELEASED_QUIET},
        '{1'b0, 32'd10,         1'b1, RELEASED_QUIET},
        '{1'b0, 32'd60,         1'b1, RELEASED_QUIET},   // stable exactly the debounce time
        '{1'b0, 32'd61,         1'b1, PRESS_EDGE},
        '{1'b0, 32'd100,        1'b0, RELEASED_QUIET},
        '{1'b1, 32'd120,        1'b1, PRESSED_QUIET},
        '{1'b1, 32'd171,        1'b1, '{1'b0, 1'b0, 1'b1, CLASS_SHORT}},
        '{1'b0, 32'd200,        1'b0, RELEASED_QUIET},
        '{1'b0, 32'd251,        1'b1, PRESS_EDGE},
        '{1'b1, 32'd260,        1'b0, RELEASED_QUIET},
        '{1'b1, 32'd1252,       1'b1, '{1'b0, 1'b0, 1'b1, CLASS_LONG}},
        '{1'b0, 32'd1300,       1'b0, RELEASED_QUIET},
        '{1'b0, 32'd1351,       1'b1, PRESS_EDGE},
        '{1'b1, 32'd1400,       1'b0, RELEASED_QUIET},
        '{1'b1, 32'd1451,       1'b1, '{1'b0, 1'b0, 1'b1, CLASS_NONE}},  // length equals short
        '{1'b0, 32'd1500,       1'b0, RELEASED_QUIET},   // bouncing contact
        '{1'b1, 32'd1520,       1'b0, RELEASED_QUIET},
        '{1'b0, 32'd1530,       1'b0, RELEASED_QUIET},
        '{1'b0, 32'd1580,       1'b1, RELEASED_QUIET},
        '{1'b0, 32'hFFFF_FFF0,  1'b1, PRESS_EDGE},
        '{1'b1, 32'hFFFF_FFF8,  1'b0, RELEASED_QUIET},
        '{1'b1, 32'h0000_0030,  1'b1, '{1'b0, 1'b0, 1'b1, CLASS_NONE}},  // across the wrap
        '{1'b0, 32'd100,        1'b0, RELEASED_QUIET},
        '{1'b0, 32'd50,         1'b1, PRESS_EDGE},       // time went backward
        '{1'b1, 32'hFFFF_FFFF,  1'b1, PRESSED_QUIET}
    };

    function automatic result_t debounce_step(input logic raw, input logic [TIME_W-1:0] now);
        logic              active;
        logic [TIME_W-1:0] held_ms;
        logic [TIME_W-1:0] press_len;
        result_t           res;
        res    = RELEASED_QUIET;
        active = (raw == cfg_model.active_level);
        if (active != pin_was_active)
            pin_edge_ms = now;
        held_ms = now - pin_edge_ms;
        if (held_ms > {16'd0, cfg_model.debounce_ms} && active != btn_pressed) begin
            btn_pressed = active;
            if (active) begin
                press_start_ms  = now;
                res.press_event = 1'b1;
            end else begin
                press_len         = now - press_start_ms;
                res.release_event = 1'b1;
                if (press_len > {16'd0, cfg_model.long_press_ms})
                    res.press_class = CLASS_LONG;
                else if (press_len > {16'd0, cfg_model.short_press_ms})
                    res.press_class = CLASS_SHORT;
            end
        end
        pin_was_active        = active;
        res.debounced_pressed = btn_pressed;
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_sample(input logic raw, input logic [TIME_W-1:0] now,
                               input logic use_typed, input result_t typed_res);
        int unsigned gap;
        result_t     predicted;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - TIME_W - 1){1'b0}}, now, raw};
        do @(posedge aclk); while (!s_tready);
        predicted = debounce_step(raw, now);
        button_results_due.push_back(use_typed ? typed_res : predicted);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic send_level(input logic active, input int unsigned delta_ms);
        sample_ms += delta_ms;
        push_sample(active ? cfg_model.active_level : ~cfg_model.active_level, sample_ms,
                    1'b0, RELEASED_QUIET);
    endtask

    // bounce, press, hold and release so that the press length lands on a chosen value
    task automatic press_sequence();
        int unsigned db;
        int unsigned len;
        int unsigned rel;
        int unsigned mid;
        db = cfg_model.debounce_ms;
        repeat ($urandom_range(0, 3)) begin
            send_level(1'b1, $urandom_range(1, db / 2 + 1));
            send_level(1'b0, $urandom_range(1, db / 2 + 1));
        end
        send_level(1'b1, $urandom_range(1, 20));
        send_level(1'b1, db);
        send_level(1'b1, 1);
        case ($urandom_range(0, 3))
            0:       len = cfg_model.short_press_ms + $urandom_range(0, 2);
            1:       len = cfg_model.long_press_ms + $urandom_range(0, 2);
            2:       len = $urandom_range(0, cfg_model.long_press_ms + 50);
            default: len = $urandom_range(0, 3 * db + 20);
        endcase
        rel = (len > db) ? len - db - 1 : 0;
        if (rel >= 2) begin
            mid = $urandom_range(1, rel - 1);
            send_level(1'b1, mid);
            send_level(1'b0, rel - mid);
        end else begin
            send_level(1'b0, rel);
        end
        if ($urandom_range(0, 3) == 0) begin
            send_level(1'b1, $urandom_range(1, db / 2 + 1));
            send_level(1'b0, $urandom_range(1, db / 2 + 1));
        end
        send_level(1'b0, db);
        send_level(1'b0, 1);
        repeat ($urandom_range(0, 2))
            send_level(1'b0, $urandom_range(0, db + 10));
    endtask

    task automatic pin_noise();
        int unsigned db;
        db = cfg_model.debounce_ms;
        repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 15) == 0)
                sample_ms = $urandom();
            else
                sample_ms += $urandom_range(0, db + 2);
            push_sample(1'($urandom_range(0, 1)), sample_ms, 1'b0, RELEASED_QUIET);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ACTIVE_LEVEL:   cfg_model.active_level   = val[0];
            REG_DEBOUNCE_MS:    cfg_model.debounce_ms    = val;
            REG_SHORT_PRESS_MS: cfg_model.short_press_ms = val;
            REG_LONG_PRESS_MS:  cfg_model.long_press_ms  = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] level_word,
                                  input logic [CFG_DATA_W-1:0] db,
                                  input logic [CFG_DATA_W-1:0] short_ms,
                                  input logic [CFG_DATA_W-1:0] long_ms,
                                  input logic stray);
        write_reg(REG_ACTIVE_LEVEL, level_word);
        write_reg(REG_DEBOUNCE_MS, db);
        // writes past the last register must change nothing
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(REG_LONG_PRESS_MS + 1, 255)),
                      CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_SHORT_PRESS_MS, short_ms);
        write_reg(REG_LONG_PRESS_MS, long_ms);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (button_results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // result side: the stall pattern switches among four modes, plus a long hold-off on request
    initial begin : result_sink
        int unsigned tick;
        int unsigned mode;
        int unsigned hold_left;
        int unsigned holdoffs_done;
        tick          = 0;
        mode          = 0;
        hold_left     = 0;
        holdoffs_done = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 128 == 0)
                mode = $urandom_range(0, 3);
            if (holdoffs_done != holdoff_requests) begin
                holdoffs_done = holdoff_requests;
                hold_left     = HOLDOFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= (tick % 4 != 3);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.debounced_pressed = m_tdata[0];
            got.press_event       = m_tdata[1];
            got.release_event     = m_tdata[2];
            got.press_class       = press_class_t'(m_tdata[4:3]);
            if (button_results_due.size() == 0) begin
                $error("result transfer with no sample pending, m_tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = button_results_due.pop_front();
                if (got.debounced_pressed !== want.debounced_pressed) begin
                    $error("debounced_pressed: expected %b, got %b",
                           want.debounced_pressed, got.debounced_pressed);
                    mismatches++;
                end
                if (got.press_event !== want.press_event) begin
                    $error("press_event: expected %b, got %b", want.press_event, got.press_event);
                    mismatches++;
                end
                if (got.release_event !== want.release_event) begin
                    $error("release_event: expected %b, got %b",
                           want.release_event, got.release_event);
                    mismatches++;
                end
                if (got.press_class !== want.press_class) begin
                    $error("press_class: expected %0d, got %0d",
                           want.press_class, got.press_class);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned target;
        cfg_model      = '{RST_ACTIVE_LEVEL, RST_DEBOUNCE_MS, RST_SHORT_PRESS_MS,
                           RST_LONG_PRESS_MS};
        pin_was_active = 1'b0;
        pin_edge_ms    = '0;
        btn_pressed    = 1'b0;
        press_start_ms = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        for (int i = 0; i < 25; i++)
            push_sample(directed_rows[i].raw, directed_rows[i].now_ms,
                        directed_rows[i].typed, directed_rows[i].want);
        s_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_settings(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
                1: apply_settings(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                2: apply_settings(16'd1, 16'd10, 16'd300, 16'd100, 1'b0);  // short above long
                4: apply_settings(CFG_DATA_W'($urandom_range(0, 65535)),
                                  CFG_DATA_W'($urandom_range(0, 65535)),
                                  CFG_DATA_W'($urandom_range(0, 65535)),
                                  CFG_DATA_W'($urandom_range(0, 65535)), 1'b1);
                default: apply_settings(CFG_DATA_W'($urandom_range(0, 1)),
                                        CFG_DATA_W'($urandom_range(0, 40)),
                                        CFG_DATA_W'($urandom_range(0, 200)),
                                        CFG_DATA_W'($urandom_range(0, 600)), 1'b0);
            endcase
            if (ph == 3)
                holdoff_requests <= holdoff_requests + 1;
            if (ph % 2 == 0)
                sample_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            else
                sample_ms = $urandom();
            target = samples_sent + PHASE_SAMPLES;
            while (samples_sent < target) begin
                if ($urandom_range(0, 3) != 0)
                    press_sequence();
                else
                    pin_noise();
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0)
            $display("PASS button_debounce_press_classifier_core");
        else
            $display("FAIL button_debounce_press_classifier_core");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL button_debounce_press_classifier_core");
        $finish;
    end

endmodule

>>> files.f
rtl/bdpc_pkg.sv
rtl/bdpc_tracker.sv
rtl/button_debounce_press_classifier_core.sv
rtl/bdpc_checker.sv
sim/testbench.sv
